@@ sv/channel_histogram_with_zero_count_top_assert.svh @@
// Assertion macros for the channel histogram block.
// Included by the top level; no other dependencies.
`ifndef CHANNEL_HISTOGRAM_WITH_ZERO_COUNT_TOP_ASSERT_SVH
`define CHANNEL_HISTOGRAM_WITH_ZERO_COUNT_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define CHZ_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: check failed");
`define CHZ_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("%m: check failed");
`else
`define CHZ_ASSERT(lbl, clk, rst_n, prop)
`define CHZ_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

@@ sv/chz_pkg.sv @@
// Shared types and codes of the channel histogram block.
// No dependencies.
package chz_pkg;

  // widest bin position that can pass the bin_count check
  localparam int unsigned POS_W = 9;

  localparam logic [1:0] MODE_ADD     = 2'd0;
  localparam logic [1:0] MODE_RD_BIN  = 2'd1;
  localparam logic [1:0] MODE_RD_CHAN = 2'd2;

  localparam logic [1:0] REG_MIN_VALUE = 2'd0;
  localparam logic [1:0] REG_BIN_SCALE = 2'd1;
  localparam logic [1:0] REG_BIN_COUNT = 2'd2;
  localparam logic [1:0] REG_ZERO_BAND = 2'd3;

  localparam logic [31:0] MIN_VALUE_RST = 32'd0;
  localparam logic [31:0] BIN_SCALE_RST = 32'd65536;
  localparam logic [8:0]  BIN_COUNT_RST = 9'd256;
  localparam logic [30:0] ZERO_BAND_RST = 31'd1;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_MUL   = 6'b000100,
    S_POS   = 6'b001000,
    S_RD    = 6'b010000,
    S_UPD   = 6'b100000
  } state_t;

  typedef struct packed {
    logic             drop;
    logic [POS_W-1:0] pos;
  } pos_res_t;

endpackage

@@ sv/channel_histogram_with_zero_count_top.sv @@
// Top level of the per-channel histogram: configuration, sequencer, count stores.
// Depends on chz_pkg, chz_pos, chz_ram and the assertion macro header.
//
// Usage: write configuration through cfg_we/cfg_index/cfg_wdata while the block
// is idle. Present a command on in_* with start high; it is taken at a rising
// edge where busy is low. Mode 0 bins a sample, mode 1 reads one bin count,
// mode 2 (and 3) reads the channel zero and nonzero counts.
// Every command gives exactly one result, shown on out_* for one cycle with
// out_valid high. The receiver cannot stall; a result must be taken when shown.
// Sequence: S_MUL does the multiply, S_POS the range check, S_RD and S_UPD the
// read-modify-write of the bin and channel memories, in turn; out_valid is
// registered from S_UPD. busy stays high until the block is back in S_IDLE.
// Reset: registers take their reset values, then a clearing pass writes zero
// to every entry, one entry a cycle (CHANNELS*BINS entries, 16384 at the
// defaults). busy stays high until it ends; configuration writes are taken.
`include "channel_histogram_with_zero_count_top_assert.svh"
module channel_histogram_with_zero_count_top #(
  parameter int unsigned CHANNELS    = 64,
  parameter int unsigned BINS        = 256,
  parameter int unsigned COUNT_WIDTH = 40
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [5:0]  in_channel,
  input  logic signed [31:0] in_sample,
  input  logic [7:0]  in_read_bin,
  output logic        out_valid,
  output logic [39:0] out_bin_value,
  output logic [39:0] out_nonzero_total,
  output logic [39:0] out_zero_total,
  output logic [7:0]  out_bin_hit,
  output logic        out_dropped
);
  import chz_pkg::*;

  localparam int unsigned BDEPTH   = CHANNELS * BINS;
  localparam int unsigned BAW      = $clog2(BDEPTH);
  localparam int unsigned CHW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned CW       = COUNT_WIDTH;
  localparam int unsigned BINS_CAP = (BINS < 512) ? BINS : 511;

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] c);
    return (c == {CW{1'b1}}) ? c : c + CW'(1);
  endfunction

  // configuration
  logic [31:0] min_value_r;
  logic [31:0] bin_scale_r;
  logic [8:0]  bin_count_r;
  logic [30:0] zero_band_r;
  logic [POS_W-1:0] limit;

  // command registers
  state_t state_r, state_nxt;
  logic [BAW-1:0]    clr_r;
  logic [1:0]        mode_r;
  logic [5:0]        ch_r;
  logic [7:0]        rbin_r;
  logic              ch_ok_r;
  logic              rbin_ok_r;
  logic              mag_ge_r;
  logic signed [33:0] diff_r;
  logic [BAW-1:0]    base_r;
  logic [BAW-1:0]    baddr_r;
  logic              accept;

  logic [31:0] mag;
  pos_res_t    res;

  // memories
  logic           bin_we, bin_re, chan_we, chan_re;
  logic [BAW-1:0] bin_waddr, bin_raddr;
  logic [CW-1:0]  bin_wdata, bin_rdata;
  logic [CHW-1:0] chan_waddr, chan_raddr;
  logic [2*CW-1:0] chan_wdata, chan_rdata;

  // update
  logic          add_ok, nz_hit, z_hit;
  logic [CW-1:0] bin_new, nz_new, z_new;
  logic [POS_W-1:0] bin_sel;

  logic        out_valid_r;
  logic [39:0] bval_nxt, nz_out_nxt, z_out_nxt;
  logic [7:0]  hit_nxt;
  logic        drop_nxt;
  logic [39:0] bval_r, nz_out_r, z_out_r;
  logic [7:0]  hit_r;
  logic        drop_r;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign limit  = ({1'b0, bin_count_r} > 10'(BINS_CAP)) ? POS_W'(BINS_CAP) : bin_count_r;
  assign mag    = in_sample[31] ? (~in_sample + 32'd1) : in_sample;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_value_r <= MIN_VALUE_RST;
      bin_scale_r <= BIN_SCALE_RST;
      bin_count_r <= BIN_COUNT_RST;
      zero_band_r <= ZERO_BAND_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_VALUE: min_value_r <= cfg_wdata;
        REG_BIN_SCALE: bin_scale_r <= cfg_wdata;
        REG_BIN_COUNT: bin_count_r <= cfg_wdata[8:0];
        REG_ZERO_BAND: zero_band_r <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_r == BAW'(BDEPTH - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (start) state_nxt = S_MUL;
      S_MUL:   state_nxt = S_POS;
      S_POS:   state_nxt = S_RD;
      S_RD:    state_nxt = S_UPD;
      S_UPD:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_UPD);
      if (state_r == S_CLEAR) begin
        clr_r <= clr_r + BAW'(1);
      end
    end
  end

  // hold the command for the whole item
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r    <= in_mode;
      ch_r      <= in_channel;
      rbin_r    <= in_read_bin;
      ch_ok_r   <= ({5'd0, in_channel} < 11'(CHANNELS));
      rbin_ok_r <= ({5'd0, in_read_bin} < 13'(BINS));
      mag_ge_r  <= (mag >= {1'b0, zero_band_r});
      diff_r    <= {{2{in_sample[31]}}, in_sample}
                   - {{2{min_value_r[31]}}, min_value_r};
      base_r    <= BAW'(in_channel) * BAW'(BINS);
    end
    if (state_r == S_RD) begin
      baddr_r <= bin_raddr;
    end
  end

  chz_pos u_pos (
    .clk         (clk),
    .diff_i      (diff_r),
    .bin_scale_i (bin_scale_r),
    .limit_i     (limit),
    .res_o       (res)
  );

  assign bin_sel    = (mode_r == MODE_ADD) ? res.pos : {1'b0, rbin_r};
  assign bin_raddr  = base_r + BAW'(bin_sel);
  assign chan_raddr = CHW'(ch_r);
  assign bin_re     = (state_r == S_RD);
  assign chan_re    = (state_r == S_RD);

  assign add_ok  = ch_ok_r && (mode_r == MODE_ADD) && !res.drop;
  assign nz_hit  = add_ok && mag_ge_r;
  assign z_hit   = add_ok && !mag_ge_r;
  assign bin_new = nz_hit ? sat_inc(bin_rdata) : bin_rdata;
  assign nz_new  = nz_hit ? sat_inc(chan_rdata[2*CW-1:CW]) : chan_rdata[2*CW-1:CW];
  assign z_new   = z_hit ? sat_inc(chan_rdata[CW-1:0]) : chan_rdata[CW-1:0];

  // clearing pass shares the write ports with the update
  always_comb begin
    if (state_r == S_CLEAR) begin
      bin_we     = 1'b1;
      bin_waddr  = clr_r;
      bin_wdata  = '0;
      chan_we    = ({1'b0, clr_r} < (BAW + 1)'(CHANNELS));
      chan_waddr = CHW'(clr_r);
      chan_wdata = '0;
    end else begin
      bin_we     = (state_r == S_UPD) && nz_hit;
      bin_waddr  = baddr_r;
      bin_wdata  = bin_new;
      chan_we    = (state_r == S_UPD) && add_ok;
      chan_waddr = CHW'(ch_r);
      chan_wdata = {nz_new, z_new};
    end
  end

  chz_ram #(
    .DEPTH (BDEPTH),
    .WIDTH (CW),
    .AW    (BAW)
  ) u_bin_ram (
    .clk   (clk),
    .we    (bin_we),
    .waddr (bin_waddr),
    .wdata (bin_wdata),
    .re    (bin_re),
    .raddr (bin_raddr),
    .rdata (bin_rdata)
  );

  chz_ram #(
    .DEPTH (CHANNELS),
    .WIDTH (2 * CW),
    .AW    (CHW)
  ) u_chan_ram (
    .clk   (clk),
    .we    (chan_we),
    .waddr (chan_waddr),
    .wdata (chan_wdata),
    .re    (chan_re),
    .raddr (chan_raddr),
    .rdata (chan_rdata)
  );

  always_comb begin
    bval_nxt   = 40'd0;
    nz_out_nxt = 40'd0;
    z_out_nxt  = 40'd0;
    hit_nxt    = 8'd0;
    drop_nxt   = 1'b0;
    if (ch_ok_r) begin
      nz_out_nxt = 40'(nz_new);
      z_out_nxt  = 40'(z_new);
      case (mode_r)
        MODE_ADD: begin
          drop_nxt = res.drop;
          if (!res.drop) begin
            bval_nxt = 40'(bin_new);
            hit_nxt  = res.pos[7:0];
          end
        end
        MODE_RD_BIN: begin
          if (rbin_ok_r) bval_nxt = 40'(bin_rdata);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_UPD) begin
      bval_r   <= bval_nxt;
      nz_out_r <= nz_out_nxt;
      z_out_r  <= z_out_nxt;
      hit_r    <= hit_nxt;
      drop_r   <= drop_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_bin_value     = bval_r;
  assign out_nonzero_total = nz_out_r;
  assign out_zero_total    = z_out_r;
  assign out_bin_hit       = hit_r;
  assign out_dropped       = drop_r;

  `CHZ_ASSERT_ALWAYS(a_reset_busy, clk, !rst_n |=> busy)
  `CHZ_ASSERT(a_out_after_upd, clk, rst_n, out_valid |-> $past(state_r == S_UPD))
  `CHZ_ASSERT(a_out_single, clk, rst_n, out_valid |=> !out_valid)
  `CHZ_ASSERT(a_bin_we_legal, clk, rst_n, bin_we |-> (state_r == S_CLEAR) || ((state_r == S_UPD) && (mode_r == MODE_ADD)))
  `CHZ_ASSERT(a_drop_clean, clk, rst_n, (out_valid && out_dropped) |-> (out_bin_value == 40'd0) && (out_bin_hit == 8'd0))

endmodule

@@ sv/chz_ram.sv @@
// Single-port-write, single-port-read synchronous memory with registered read data.
// No dependencies.
module chz_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 40,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/chz_pos.sv @@
// Bin position unit: registered 32x32 multiply, then add and range check.
// Depends on chz_pkg.
module chz_pos (
  input  logic                   clk,
  input  logic signed [33:0]     diff_i,
  input  logic [31:0]            bin_scale_i,
  input  logic [chz_pkg::POS_W-1:0] limit_i,
  output chz_pkg::pos_res_t      res_o
);
  import chz_pkg::*;

  logic [63:0] prod_r;
  logic        hi_r;
  logic        neg_r;
  logic        pos_zero_r;
  logic [32:0] pos;
  pos_res_t    res_nxt;
  pos_res_t    res_r;

  always_ff @(posedge clk) begin
    prod_r     <= 64'(diff_i[31:0]) * 64'(bin_scale_i);
    hi_r       <= diff_i[32];
    neg_r      <= diff_i[33] && (bin_scale_i != 32'd0);
    pos_zero_r <= diff_i[33] || (diff_i == 34'sd0);
    res_r      <= res_nxt;
  end

  always_comb begin
    if (pos_zero_r) begin
      pos = 33'd0;
    end else begin
      pos = (hi_r ? {1'b0, bin_scale_i} : 33'd0) + {1'b0, prod_r[63:32]};
    end
    res_nxt.drop = neg_r || (pos >= {24'd0, limit_i});
    res_nxt.pos  = pos[POS_W-1:0];
  end

  assign res_o = res_r;

endmodule

@@ tb/sv/tb_channel_histogram_with_zero_count_top.sv @@
// Self-checking testbench for the per-channel histogram block.
// Predicts every result from a private copy of the counters; depends only on chz_pkg
// and channel_histogram_with_zero_count_top.
module tb_channel_histogram_with_zero_count_top;
  import chz_pkg::*;

  localparam logic [1:0]  MODE_SPARE = 2'd3;
  localparam logic [39:0] COUNT_MAX  = 40'hFF_FFFF_FFFF;
  localparam int          CYCLE_LIMIT = 500000;

  typedef struct {
    logic [1:0]         mode;
    logic [5:0]         channel;
    logic signed [31:0] sample;
    logic [7:0]         read_bin;
  } hist_cmd_t;

  typedef struct {
    logic [39:0] bin_value;
    logic [39:0] nonzero_total;
    logic [39:0] zero_total;
    logic [7:0]  bin_hit;
    logic        dropped;
  } hist_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_mode = '0;
  logic [5:0] in_channel = '0;
  logic signed [31:0] in_sample = '0;
  logic [7:0] in_read_bin = '0;
  logic out_valid;
  logic [39:0] out_bin_value;
  logic [39:0] out_nonzero_total;
  logic [39:0] out_zero_total;
  logic [7:0] out_bin_hit;
  logic out_dropped;

  // model copy of the configuration and the count stores
  logic signed [31:0] min_value_q = MIN_VALUE_RST;
  logic [31:0] bin_scale_q = BIN_SCALE_RST;
  logic [8:0]  bin_count_q = BIN_COUNT_RST;
  logic [30:0] zero_band_q = ZERO_BAND_RST;
  logic [39:0] bin_store [16384];
  logic [39:0] nonzero_store [64];
  logic [39:0] zero_store [64];

  hist_cmd_t pending_cmds [$];
  hist_res_t expected_results [$];
  int errors = 0;
  int cycles = 0;
  int burst_left = 0;
  int gap_left = 0;

  channel_histogram_with_zero_count_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .start            (start),
    .busy             (busy),
    .in_mode          (in_mode),
    .in_channel       (in_channel),
    .in_sample        (in_sample),
    .in_read_bin      (in_read_bin),
    .out_valid        (out_valid),
    .out_bin_value    (out_bin_value),
    .out_nonzero_total(out_nonzero_total),
    .out_zero_total   (out_zero_total),
    .out_bin_hit      (out_bin_hit),
    .out_dropped      (out_dropped)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [39:0] bump_count(logic [39:0] c);
    return (c == COUNT_MAX) ? c : c + 40'd1;
  endfunction

  // bins in use: a bin_count above 256 acts as 256
  function automatic longint unsigned bins_in_use();
    return (bin_count_q > 9'd256) ? 256 : longint'(bin_count_q);
  endfunction

  function automatic hist_res_t predict_histogram(hist_cmd_t c);
    hist_res_t r;
    longint diff;
    longint mag;
    longint unsigned lim;
    longint unsigned scale;
    longint unsigned d;
    longint unsigned pos;
    logic neg;
    logic [13:0] slot;
    r = '{default: '0};
    if (c.mode == MODE_ADD) begin
      diff = longint'(c.sample) - longint'(min_value_q);
      scale = 64'(bin_scale_q);
      lim = bins_in_use();
      // a zero scale maps everything, below the edge too, to bin 0
      neg = (diff < 0) && (scale != 0);
      pos = 0;
      if (!neg && diff > 0) begin
        d = diff;
        pos = (d >> 32) * scale + (((d & 64'hFFFF_FFFF) * scale) >> 32);
      end
      if (neg || pos >= lim) begin
        r.dropped = 1'b1;
      end else begin
        slot = {c.channel, pos[7:0]};
        mag = (c.sample < 0) ? -longint'(c.sample) : longint'(c.sample);
        if (mag >= longint'(zero_band_q)) begin
          bin_store[slot] = bump_count(bin_store[slot]);
          nonzero_store[c.channel] = bump_count(nonzero_store[c.channel]);
        end else begin
          zero_store[c.channel] = bump_count(zero_store[c.channel]);
        end
        r.bin_value = bin_store[slot];
        r.bin_hit = pos[7:0];
      end
    end else if (c.mode == MODE_RD_BIN) begin
      r.bin_value = bin_store[{c.channel, c.read_bin}];
    end
    r.nonzero_total = nonzero_store[c.channel];
    r.zero_total = zero_store[c.channel];
    return r;
  endfunction

  function automatic hist_cmd_t mk_cmd(logic [1:0] mode, logic [5:0] ch,
                                       logic [31:0] smp, logic [7:0] rb);
    hist_cmd_t c;
    c.mode = mode;
    c.channel = ch;
    c.sample = smp;
    c.read_bin = rb;
    return c;
  endfunction

  // mostly samples aimed into the binning interval, a few channels so counts build up
  function automatic hist_cmd_t random_cmd();
    hist_cmd_t c;
    longint unsigned lim;
    longint unsigned span;
    longint unsigned near;
    int unsigned span32;
    int unsigned pick;
    lim = bins_in_use();
    if (lim == 0) span = 0;
    else if (bin_scale_q == 0) span = 64'hFFFF_FFFF;
    else span = (lim << 32) / bin_scale_q;
    if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
    span32 = 32'(span);
    near = 2 * longint'(zero_band_q);
    if (near > 64'h7FFF_FFFF) near = 64'h7FFF_FFFF;

    pick = $urandom_range(0, 99);
    if (pick < 70) c.mode = MODE_ADD;
    else if (pick < 82) c.mode = MODE_RD_BIN;
    else if (pick < 94) c.mode = MODE_RD_CHAN;
    else c.mode = MODE_SPARE;
    c.channel = ($urandom_range(0, 3) != 0) ? 6'($urandom_range(0, 3))
                                            : 6'($urandom_range(0, 63));
    if (lim > 0 && $urandom_range(0, 4) != 0)
      c.read_bin = 8'($urandom_range(0, 32'(lim - 1)));
    else c.read_bin = 8'($urandom_range(0, 255));

    pick = $urandom_range(0, 9);
    if (pick <= 5) begin
      c.sample = min_value_q + 32'($urandom_range(0, span32));
    end else if (pick == 6) begin
      c.sample = 32'($urandom_range(0, 32'(near)));
      if ($urandom_range(0, 1)) c.sample = -c.sample;
    end else if (pick == 7) begin
      // straddle the lower or upper edge of the interval
      c.sample = min_value_q + ($urandom_range(0, 1) ? span32 : 32'd0)
                 + 32'($urandom_range(0, 4)) - 32'd2;
    end else if (pick == 8) begin
      c.sample = $urandom;
    end else begin
      c.sample = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    end
    return c;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_MIN_VALUE: min_value_q = data;
      REG_BIN_SCALE: bin_scale_q = data;
      REG_BIN_COUNT: bin_count_q = data[8:0];
      REG_ZERO_BAND: zero_band_q = data[30:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || start || expected_results.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic run_phase(logic [31:0] mn, logic [31:0] sc, logic [8:0] cnt,
                           logic [30:0] band, int n);
    logic [31:0] w;
    wait_idle();
    write_reg(REG_MIN_VALUE, mn);
    write_reg(REG_BIN_SCALE, sc);
    // junk in the unused upper bits
    w = $urandom;
    w[8:0] = cnt;
    write_reg(REG_BIN_COUNT, w);
    write_reg(REG_ZERO_BAND, {1'($urandom_range(0, 1)), band});
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    repeat (n) pending_cmds.push_back(random_cmd());
  endtask

  // driver: bursts of commands with random gaps
  always @(posedge clk) begin : drive_cmds
    hist_cmd_t nxt;
    if (!rst_n) begin
      start <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (start && !busy)
        expected_results.push_back(
          predict_histogram(mk_cmd(in_mode, in_channel, in_sample, in_read_bin)));
      if (start && busy) begin
        // hold until the transfer
      end else if (gap_left > 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_cmds.size() != 0) begin
        nxt = pending_cmds.pop_front();
        in_mode <= nxt.mode;
        in_channel <= nxt.channel;
        in_sample <= nxt.sample;
        in_read_bin <= nxt.read_bin;
        start <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: every strobed result against the oldest prediction
  always @(posedge clk) begin : check_results
    hist_res_t exp_r;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with no command outstanding", $time);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_bin_value !== exp_r.bin_value) begin
          $display("%0t: bin_value expected %h got %h", $time, exp_r.bin_value, out_bin_value);
          errors++;
        end
        if (out_nonzero_total !== exp_r.nonzero_total) begin
          $display("%0t: nonzero_total expected %h got %h", $time,
                   exp_r.nonzero_total, out_nonzero_total);
          errors++;
        end
        if (out_zero_total !== exp_r.zero_total) begin
          $display("%0t: zero_total expected %h got %h", $time,
                   exp_r.zero_total, out_zero_total);
          errors++;
        end
        if (out_bin_hit !== exp_r.bin_hit) begin
          $display("%0t: bin_hit expected %h got %h", $time, exp_r.bin_hit, out_bin_hit);
          errors++;
        end
        if (out_dropped !== exp_r.dropped) begin
          $display("%0t: dropped expected %b got %b", $time, exp_r.dropped, out_dropped);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    foreach (bin_store[i]) bin_store[i] = '0;
    foreach (nonzero_store[i]) begin
      nonzero_store[i] = '0;
      zero_store[i] = '0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    // let the clearing pass finish
    do @(negedge clk); while (busy !== 1'b0);

    // reset settings: unit bins from 0.0, 256 bins, a zero band of one LSB
    pending_cmds.push_back(mk_cmd(MODE_ADD, 6'd0, 32'h0000_0000, 8'd0));
    pending_cmds.push_back(mk_cmd(MODE_ADD, 6'd0, 32'h0000_0001, 8'd0));
    pending_cmds.push_back(mk_cmd(MODE_ADD, 6'd63, 32'h00FF_FFFF, 8'd0));
    pending_cmds.push_back(mk_cmd(MODE_ADD, 6'd63, 32'h00FF_FFFF, 8'd0));
    pending_cmds.push_back(mk_cmd(MODE_ADD, 6'd63, 32'h0100_0000, 8'd0));
    pending_cmds.push_back(mk_cmd(MODE_ADD, 6'd5, 32'hFFFF_FFFF, 8'd0));
    pending_cmds.push_back(mk_cmd(MODE_ADD, 6'd5, 32'h7FFF_FFFF, 8'd0));
    pending_cmds.push_back(mk_cmd(MODE_ADD, 6'd5, 32'h8000_0000, 8'd0));
    pending_cmds.push_back(mk_cmd(MODE_ADD, 6'd5, 32'h0005_8000, 8'd0));
    pending_cmds.push_back(mk_cmd(MODE_ADD, 6'd5, 32'h0005_0000, 8'd0));
    pending_cmds.push_back(mk_cmd(MODE_ADD, 6'd42, 32'h00AA_0000, 8'd0));
    pending_cmds.push_back(mk_cmd(MODE_ADD, 6'd21, 32'h0055_1234, 8'd0));
    pending_cmds.push_back(mk_cmd(MODE_RD_BIN, 6'd0, 32'h0, 8'd0));
    pending_cmds.push_back(mk_cmd(MODE_RD_BIN, 6'd63, 32'hFFFF_FFFF, 8'd255));
    pending_cmds.push_back(mk_cmd(MODE_RD_BIN, 6'd5, 32'h0, 8'd5));
    pending_cmds.push_back(mk_cmd(MODE_RD_BIN, 6'd42, 32'h0, 8'hAA));
    pending_cmds.push_back(mk_cmd(MODE_RD_BIN, 6'd21, 32'h0, 8'h55));
    pending_cmds.push_back(mk_cmd(MODE_RD_CHAN, 6'd0, 32'h0, 8'd0));
    pending_cmds.push_back(mk_cmd(MODE_RD_CHAN, 6'd63, 32'h0, 8'hFF));
    pending_cmds.push_back(mk_cmd(MODE_SPARE, 6'd5, 32'h0, 8'd0));
    pending_cmds.push_back(mk_cmd(MODE_RD_BIN, 6'd7, 32'h0, 8'd200));
    repeat (110) pending_cmds.push_back(random_cmd());

    // 1/16 unit bins from -8.0, half-unit zero band
    run_phase(32'hFFF8_0000, 32'h0010_0000, 9'd256, 31'h0000_8000, 150);
    // one bin over the whole range, widest zero band
    run_phase(32'h8000_0000, 32'h0000_0001, 9'd1, 31'h7FFF_FFFF, 100);
    // no bins: every sample drops
    run_phase(32'h7FFF_FFFF, 32'hFFFF_FFFF, 9'd0, 31'h0, 60);
    // zero scale puts everything in bin 0; bin_count above the bin total
    run_phase($urandom, 32'h0, 9'd300, 31'h0, 100);
    // finest bins
    run_phase(32'hFF9C_0000, 32'hFFFF_FFFF, 9'd256, 31'h1, 120);
    repeat (3)
      run_phase($urandom, $urandom_range(32'h1000, 32'h40_0000),
                9'($urandom_range(1, 256)), 31'($urandom_range(0, 32'h4_0000)), 120);

    wait_idle();
    repeat (10) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
